/* src/atb_pkg.sv */
// ----------------------------------------------------------------------------
// Allocation tracker package
// Shared constants, codes and types for the allocation tracker with budget.
// ----------------------------------------------------------------------------
package atb_pkg;

  localparam int MAX_BLOCKS   = 1024;
  localparam int ADDR_BITS    = 32;
  localparam int SIZE_W       = 31;
  localparam int CNT_W        = 11;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int OPCODE_W     = 2;
  localparam int STATUS_W     = 2;

  localparam int IN_FIELDS_W  = ADDR_BITS + SIZE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + 2 * SIZE_W + CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] BUDGET_RESET = SIZE_W'(10000);
  localparam logic [CNT_W-1:0]  CNT_MAX      = CNT_W'(MAX_BLOCKS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE     = 2'd1,
    OP_FREE_ALL = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BUDGET    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_MOVE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0]    size;
    logic [ADDR_BITS-1:0] addr;
  } entry_t;

endpackage

/* src/atb_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module atb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/allocation_tracker_with_budget.sv */
// ----------------------------------------------------------------------------
// Allocation tracker with budget
// Records allocated blocks in a table, checks them against a byte budget and
// the table depth, and releases them by address or all at once.
// ----------------------------------------------------------------------------
//   Channel   Direction  Carries
//   in_       slave      request: opcode in tuser, address and size in tdata
//   out_      master     result: status, freed size, byte total, block count
//   cfg_      write      byte budget
//
// Allocate, free-all and the unused opcode pass through S_EXEC to S_RESP,
// which registers the result. A free reads the table one entry per cycle
// through the single read port in S_SCAN, and on a match moves the last
// entry into the freed slot in S_MOVE. One request is in work at a time.
// Reset clears both totals and sets the budget to 10000; table contents are
// not cleared. A stalled result holds the next request in S_RESP until taken.
// ----------------------------------------------------------------------------
module allocation_tracker_with_budget
  import atb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // [1:0] opcode
  input  logic [OPCODE_W-1:0]    in_tuser,
  // [31:0] block_address, [62:32] block_size, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] status, [32:2] freed_size, [63:33] total_bytes, [74:64] total_blocks
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [SIZE_W-1:0]      cfg_wdata
);

  state_t               state_r, state_nxt;
  opcode_t              op_r, op_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SIZE_W-1:0]    total_r, total_nxt;
  logic [SIZE_W-1:0]    budget_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [SIZE_W-1:0]    freed_r, freed_nxt;
  status_t              status_r, status_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  entry_t               mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  entry_t               mem_rdata;

  logic [SIZE_W:0]      sum_ext;
  logic [IDX_W-1:0]     last_idx;

  assign sum_ext  = {1'b0, total_r} + {1'b0, size_r};
  assign last_idx = IDX_W'(count_r - CNT_W'(1));

  atb_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      total_r      <= '0;
      budget_r     <= BUDGET_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      total_r      <= total_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    size_r      <= size_nxt;
    idx_r       <= idx_nxt;
    freed_r     <= freed_nxt;
    status_r    <= status_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    freed_nxt      = freed_r;
    status_nxt     = status_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = '{size: size_r, addr: addr_r};
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = opcode_t'(in_tuser);
          addr_nxt  = in_tdata[ADDR_BITS-1:0];
          size_nxt  = in_tdata[ADDR_BITS +: SIZE_W];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = ST_OK;
        freed_nxt  = '0;
        idx_nxt    = '0;
        state_nxt  = S_RESP;
        unique case (op_r)
          OP_ALLOC: begin
            if (sum_ext > {1'b0, budget_r}) begin
              status_nxt = ST_BUDGET;
            end else if (count_r >= CNT_MAX) begin
              status_nxt = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = IDX_W'(count_r);
              count_nxt = count_r + CNT_W'(1);
              total_nxt = sum_ext[SIZE_W-1:0];
            end
          end
          OP_FREE: begin
            if (count_r == '0) begin
              status_nxt = ST_NOT_FOUND;
            end else begin
              mem_raddr = '0;
              state_nxt = S_SCAN;
            end
          end
          OP_FREE_ALL: begin
            freed_nxt = total_r;
            total_nxt = '0;
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (mem_rdata.addr == addr_r) begin
          freed_nxt = mem_rdata.size;
          mem_raddr = last_idx;
          state_nxt = S_MOVE;
        end else if (idx_r == last_idx) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_RESP;
        end else begin
          mem_raddr = idx_r + IDX_W'(1);
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        count_nxt = count_r - CNT_W'(1);
        total_nxt = (total_r >= freed_r) ? (total_r - freed_r) : '0;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = OUT_TDATA_W'({count_r, total_r, freed_r, status_r});
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

endmodule

/* src/atb_checker.sv */
// ----------------------------------------------------------------------------
// Allocation tracker checker
// Port-level properties of the allocation tracker, bound to the top level.
// ----------------------------------------------------------------------------
module atb_checker
  import atb_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   freed;
  logic [CNT_W-1:0]    blocks;

  assign status = out_tdata[STATUS_W-1:0];
  assign freed  = out_tdata[STATUS_W +: SIZE_W];
  assign blocks = out_tdata[STATUS_W + 2 * SIZE_W +: CNT_W];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request accepted while one is in work");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> blocks <= CNT_MAX)
    else $error("block count beyond table depth");

  a_refused_frees_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status != ST_OK) |-> freed == '0)
    else $error("refused request reports freed bytes");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (status == ST_FULL) |-> blocks == CNT_MAX)
    else $error("table full reported with free entries");

endmodule

bind allocation_tracker_with_budget atb_checker u_atb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

/* tb/sv/allocation_tracker_checker.sv */
// ----------------------------------------------------------------------------
// Allocation tracker checker
// Watches the request, result and budget ports of the allocation tracker. It
// keeps its own copy of the block table, the totals and the budget, works out
// the result of every accepted request, and compares each accepted result with
// the oldest outstanding prediction field by field.
// ----------------------------------------------------------------------------
module allocation_tracker_checker
  import atb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [OPCODE_W-1:0]    in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [SIZE_W-1:0]      cfg_wdata,
  output int                     failures,
  output int                     pending
);

  // The field order matches out_tdata from the highest used bit down.
  typedef struct packed {
    logic [CNT_W-1:0]  total_blocks;
    logic [SIZE_W-1:0] total_bytes;
    logic [SIZE_W-1:0] freed;
    status_t           status;
  } tally_t;

  logic [ADDR_BITS-1:0] shadow_addr [MAX_BLOCKS];
  logic [SIZE_W-1:0]    shadow_size [MAX_BLOCKS];
  int unsigned          shadow_count;
  logic [SIZE_W-1:0]    shadow_bytes;
  logic [SIZE_W-1:0]    shadow_budget;
  tally_t               tally_q [$];
  int                   error_count = 0;

  function automatic tally_t track_request(input logic [OPCODE_W-1:0]  op,
                                           input logic [ADDR_BITS-1:0] addr,
                                           input logic [SIZE_W-1:0]    size);
    tally_t      result;
    int unsigned slot;
    result.status = ST_OK;
    result.freed  = '0;
    case (op)
      OP_ALLOC: begin
        if ({1'b0, shadow_bytes} + {1'b0, size} > {1'b0, shadow_budget}) begin
          result.status = ST_BUDGET;
        end else if (shadow_count >= MAX_BLOCKS) begin
          result.status = ST_FULL;
        end else begin
          shadow_addr[shadow_count] = addr;
          shadow_size[shadow_count] = size;
          shadow_count++;
          shadow_bytes = shadow_bytes + size;
        end
      end
      OP_FREE: begin
        slot = 0;
        while (slot < shadow_count && shadow_addr[slot] != addr) slot++;
        if (slot == shadow_count) begin
          result.status = ST_NOT_FOUND;
        end else begin
          result.freed = shadow_size[slot];
          shadow_bytes = (shadow_bytes >= result.freed) ? shadow_bytes - result.freed : '0;
          shadow_count--;
          shadow_addr[slot] = shadow_addr[shadow_count];
          shadow_size[slot] = shadow_size[shadow_count];
        end
      end
      OP_FREE_ALL: begin
        result.freed = shadow_bytes;
        shadow_bytes = '0;
        shadow_count = 0;
      end
      default: begin
      end
    endcase
    result.total_bytes  = shadow_bytes;
    result.total_blocks = CNT_W'(shadow_count);
    return result;
  endfunction

  always @(posedge clk) begin
    tally_t seen;
    tally_t want;
    if (!rst_n) begin
      shadow_count  = 0;
      shadow_bytes  = '0;
      shadow_budget = BUDGET_RESET;
      tally_q.delete();
    end else begin
      if (cfg_we) begin
        shadow_budget = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        tally_q.push_back(track_request(in_tuser, in_tdata[ADDR_BITS-1:0],
                                        in_tdata[ADDR_BITS +: SIZE_W]));
      end
      if (out_tvalid && out_tready) begin
        seen = tally_t'(out_tdata[$bits(tally_t)-1:0]);
        if (tally_q.size() == 0) begin
          $display("%0t: result with no request outstanding, tdata %h", $time, out_tdata);
          error_count++;
        end else begin
          want = tally_q.pop_front();
          if (seen.status != want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, seen.status);
            error_count++;
          end
          if (seen.freed != want.freed) begin
            $display("%0t: freed_size expected %0d got %0d", $time, want.freed, seen.freed);
            error_count++;
          end
          if (seen.total_bytes != want.total_bytes) begin
            $display("%0t: total_bytes expected %0d got %0d", $time, want.total_bytes,
                     seen.total_bytes);
            error_count++;
          end
          if (seen.total_blocks != want.total_blocks) begin
            $display("%0t: total_blocks expected %0d got %0d", $time, want.total_blocks,
                     seen.total_blocks);
            error_count++;
          end
        end
      end
    end
    failures <= error_count;
    pending  <= tally_q.size();
  end

endmodule

/* tb/sv/tb_allocation_tracker_with_budget.sv */
// ----------------------------------------------------------------------------
// Allocation tracker testbench
// Drives allocate, free, free-all and unused requests into the tracker with
// random gaps and result back-pressure, writes the byte budget between phases,
// fills the table to its depth once, and lets the checker compare every result.
// ----------------------------------------------------------------------------
module tb_allocation_tracker_with_budget;
  import atb_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_RESERVED     = 2'd3;
  localparam logic [SIZE_W-1:0]   BUDGET_MAX      = '1;
  localparam int                  WATCHDOG_LIMIT  = 6000;
  localparam int                  SETTLE_CYCLES   = 40;
  localparam int                  RANDOM_REQUESTS = 580;
  localparam int                  SEGMENTS        = 6;
  localparam int                  POOL_DEPTH      = 64;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [OPCODE_W-1:0]    in_tuser   = '0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [SIZE_W-1:0]      cfg_wdata  = '0;
  int                     failures;
  int                     pending;
  bit                     no_idle     = 1'b0;
  int unsigned            stall_left  = 0;
  int unsigned            idle_cycles = 0;
  logic [SIZE_W-1:0]      budget_now  = BUDGET_RESET;
  logic [ADDR_BITS-1:0]   addr_pool [$];

  always #6 clk = ~clk;

  allocation_tracker_with_budget dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  allocation_tracker_checker tracker_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .failures   (failures),
    .pending    (pending)
  );

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    int unsigned gap;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else begin
      gap = pick_gap();
      stall_left <= gap;
      out_tready <= (gap == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_allocation_tracker_with_budget: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(input logic [OPCODE_W-1:0]  op,
                              input logic [ADDR_BITS-1:0] addr,
                              input logic [SIZE_W-1:0]    size);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'({size, addr});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (op == OP_ALLOC) begin
      if (addr_pool.size() >= POOL_DEPTH) void'(addr_pool.pop_front());
      addr_pool.push_back(addr);
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_budget(input logic [SIZE_W-1:0] value);
    settle();
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    budget_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned          roll;
    int unsigned          reuse;
    logic [OPCODE_W-1:0]  op;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_W-1:0]    size;
    roll = $urandom_range(0, 99);
    if (roll < 52) begin
      op = OP_ALLOC;
    end else if (roll < 88) begin
      op = OP_FREE;
    end else if (roll < 94) begin
      op = OP_FREE_ALL;
    end else begin
      op = OP_RESERVED;
    end
    reuse = (op == OP_FREE) ? 75 : 25;
    addr = $urandom;
    if (addr_pool.size() != 0 && $urandom_range(0, 99) < reuse) begin
      addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    end
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      size = SIZE_W'($urandom_range(0, budget_now / 6));
    end else if (roll < 90) begin
      size = SIZE_W'($urandom);
    end else if (roll < 95) begin
      size = '0;
    end else begin
      size = BUDGET_MAX;
    end
    send_request(op, addr, size);
  endtask

  initial begin
    logic [ADDR_BITS-1:0] deep_addr;
    logic [SIZE_W-1:0]    seg_budget;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_FREE, '0, '0);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, '1, SIZE_W'(10000));
    send_request(OP_ALLOC, 32'h0000_0001, 31'd1);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_FREE, '0, '1);
    send_request(OP_FREE, '1, '0);
    send_request(OP_RESERVED, '1, '1);
    send_request(OP_FREE, '0, '0);
    send_request(OP_FREE, '0, '0);
    send_request(OP_ALLOC, 32'h1234_5678, 31'd5000);
    send_request(OP_ALLOC, 32'hA5A5_A5A5, 31'd4000);
    send_request(OP_FREE_ALL, 32'h5A5A_5A5A, 31'd77);
    send_request(OP_FREE_ALL, '0, '0);
    set_budget(BUDGET_MAX);
    send_request(OP_ALLOC, 32'h8000_0000, BUDGET_MAX);
    send_request(OP_ALLOC, 32'h8000_0001, '0);
    send_request(OP_ALLOC, 32'h8000_0002, 31'd1);
    send_request(OP_FREE, 32'h8000_0000, '0);
    set_budget('0);
    send_request(OP_ALLOC, 32'h0000_0040, '0);
    send_request(OP_ALLOC, 32'h0000_0080, 31'd1);
    set_budget(BUDGET_RESET);
    send_request(OP_ALLOC, 32'h0000_0100, 31'd3000);
    send_request(OP_ALLOC, 32'h0000_0200, 31'd3000);
    // The new budget lies below the bytes already held.
    set_budget(31'd1000);
    send_request(OP_ALLOC, 32'h0000_0300, '0);
    send_request(OP_FREE, 32'h0000_0100, '0);
    send_request(OP_FREE_ALL, '0, '0);

    // Fill the table to its depth, then hit the full and budget limits together.
    set_budget(BUDGET_MAX);
    no_idle = 1'b1;
    deep_addr = 32'h7777_0000;
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      if (k == MAX_BLOCKS - 1) begin
        send_request(OP_ALLOC, deep_addr, SIZE_W'($urandom_range(1, 4095)));
      end else if (k % 100 == 7) begin
        send_request(OP_ALLOC, 32'h0000_1000, SIZE_W'($urandom_range(1, 4095)));
      end else begin
        send_request(OP_ALLOC, $urandom, SIZE_W'($urandom_range(1, 4095)));
      end
    end
    no_idle = 1'b0;
    send_request(OP_ALLOC, $urandom, BUDGET_MAX);
    send_request(OP_ALLOC, $urandom, '0);
    send_request(OP_FREE, deep_addr, '0);
    send_request(OP_FREE, 32'h0000_1000, '0);
    send_request(OP_FREE, 32'hDEAD_0001, '0);
    send_request(OP_ALLOC, $urandom, 31'd5);
    send_request(OP_ALLOC, $urandom, 31'd6);
    send_request(OP_ALLOC, $urandom, 31'd7);
    send_request(OP_FREE_ALL, '0, '0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0:       seg_budget = BUDGET_RESET;
        1:       seg_budget = SIZE_W'($urandom);
        2:       seg_budget = 31'd300;
        3:       seg_budget = BUDGET_MAX;
        4:       seg_budget = '0;
        default: seg_budget = SIZE_W'($urandom_range(1000, 100000));
      endcase
      set_budget(seg_budget);
      no_idle = (seg == 1) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < RANDOM_REQUESTS / SEGMENTS; n++) begin
        random_request();
      end
    end
    no_idle = 1'b0;

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tb_allocation_tracker_with_budget: clean");
    end else begin
      $display("tb_allocation_tracker_with_budget: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/atb_pkg.sv
src/atb_ram.sv
src/allocation_tracker_with_budget.sv
src/atb_checker.sv
tb/sv/allocation_tracker_checker.sv
tb/sv/tb_allocation_tracker_with_budget.sv
